[rtl/gba_pkg.sv]
package gba_pkg;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_TAKE   = 2'd1;
  localparam logic [1:0] ACT_RETURN = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [0:0] REG_BPG    = 1'b0;
  localparam logic [0:0] REG_BCOUNT = 1'b1;

  localparam logic [10:0] USED_MAX  = 11'd2047;
  localparam logic [12:0] TOTAL_MAX = 13'd8191;

  typedef struct packed {
    logic hit;
    logic miss;
  } scan_stat_t;

endpackage

[rtl/grouped_bitmap_block_allocator.sv]
// Channel | Dir | Handshake              | Payload
// in      | in  | in_tvalid / in_tready  | tuser: action; tdata: target_index
// out     | out | out_tvalid / out_tready| tuser: status; tdata: index, group/total free
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item at a time. Allocate: group count (one step per group), then a scan of the
// bitmap words up to the first free bit (one word per cycle on the bitmap RAM read port).
// Take/return: group count, then group lookup. The next item can be taken in the same
// cycle as a result is presented. After reset a clearing pass over all bitmap words
// zeroes both RAMs; no item is taken meanwhile. A stalled output holds the next item in
// its emit step.
module grouped_bitmap_block_allocator #(
  parameter int GROUPS         = 4,
  parameter int BITS_PER_GROUP = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] target_index
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] result_index, [22:12] group_free, [35:23] total_free
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int N     = GROUPS * BITS_PER_GROUP;
  localparam int WORDS = (N + 31) / 32;
  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int GW    = GROUPS > 1 ? $clog2(GROUPS) : 1;
  localparam int GGW   = $clog2(GROUPS + 1);
  localparam int BW    = $clog2(BITS_PER_GROUP + 1);
  localparam int PXW   = $clog2(N + BITS_PER_GROUP + 1);
  localparam int CW    = $clog2((GROUPS + 1) * BITS_PER_GROUP + 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_GCNT = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_MOD  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]     state_r;
  logic [2:0]     state_nxt;
  logic [AW-1:0]  clr_r;

  logic [10:0]    bpg_cfg_r;
  logic [12:0]    bc_r;
  logic [BW-1:0]  ebpg_in;

  logic [1:0]     action_r;
  logic [11:0]    target_r;
  logic [BW-1:0]  ebpg_r;
  logic [GGW-1:0] gc_r;
  logic [CW-1:0]  cap_r;
  logic [11:0]    rem_r;
  logic [GGW-1:0] g_r;
  logic [PXW-1:0] sb_r;
  logic [PXW-1:0] div_pos;
  logic           gc_step;

  logic [AW-1:0]  op_addr_r;
  logic [4:0]     op_bit_r;
  logic [GW-1:0]  op_g_r;
  logic           op_set_r;

  logic [11:0]    res_index_r;
  logic [1:0]     res_status_r;
  logic [10:0]    res_gfree_r;
  logic [12:0]    total_used_r;
  logic [12:0]    total_free;

  logic           out_tvalid_r;
  logic [39:0]    out_tdata_r;
  logic [1:0]     out_tuser_r;

  logic           bm_we;
  logic [AW-1:0]  bm_waddr;
  logic [31:0]    bm_wdata;
  logic [AW-1:0]  bm_raddr;
  logic [31:0]    bm_rdata;
  logic           used_we;
  logic [GW-1:0]  used_waddr;
  logic [10:0]    used_rdata;
  logic [31:0]    word_mod;
  logic [10:0]    used_mod;
  logic [12:0]    total_mod;
  logic [10:0]    gfree_mod;

  logic                 scan_start;
  gba_pkg::scan_stat_t  scan_stat;
  logic [AW-1:0]        scan_raddr;
  logic [AW-1:0]        hit_addr;
  logic [4:0]           hit_bit;
  logic [GW-1:0]        hit_g;
  logic [PXW-1:0]       hit_index;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    if (bpg_cfg_r == 11'd0) begin
      ebpg_in = BW'(1);
    end else if (32'(bpg_cfg_r) > BITS_PER_GROUP) begin
      ebpg_in = BW'(BITS_PER_GROUP);
    end else begin
      ebpg_in = BW'(bpg_cfg_r);
    end
  end

  assign gc_step = (32'(gc_r) < GROUPS) && (32'(cap_r) + 32'(ebpg_r) <= 32'(bc_r));
  assign div_pos = sb_r + PXW'(rem_r);
  assign scan_start = (state_r == ST_GCNT) && !gc_step && (action_r == gba_pkg::ACT_ALLOC);

  // read-modify-write of one bitmap word, one group count and the total used count
  always_comb begin
    if (op_set_r) begin
      word_mod  = bm_rdata | (32'd1 << op_bit_r);
      used_mod  = (used_rdata < gba_pkg::USED_MAX) ? used_rdata + 1'b1 : used_rdata;
      total_mod = (total_used_r < gba_pkg::TOTAL_MAX) ? total_used_r + 1'b1 : total_used_r;
    end else begin
      word_mod  = bm_rdata & ~(32'd1 << op_bit_r);
      used_mod  = (used_rdata != 11'd0) ? used_rdata - 1'b1 : used_rdata;
      total_mod = (total_used_r != 13'd0) ? total_used_r - 1'b1 : total_used_r;
    end
    if (32'(used_mod) >= 32'(ebpg_r)) begin
      gfree_mod = 11'd0;
    end else begin
      gfree_mod = 11'(32'(ebpg_r) - 32'(used_mod));
    end
    if (32'(total_used_r) >= 32'(cap_r)) begin
      total_free = 13'd0;
    end else begin
      total_free = 13'(32'(cap_r) - 32'(total_used_r));
    end
  end

  always_comb begin
    bm_we      = (state_r == ST_CLR) || (state_r == ST_MOD);
    bm_waddr   = (state_r == ST_CLR) ? clr_r : op_addr_r;
    bm_wdata   = (state_r == ST_CLR) ? 32'd0 : word_mod;
    bm_raddr   = (state_r == ST_SCAN) ? scan_raddr : op_addr_r;
    used_we    = ((state_r == ST_CLR) && (32'(clr_r) < GROUPS)) || (state_r == ST_MOD);
    used_waddr = (state_r == ST_CLR) ? GW'(clr_r) : op_g_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_GCNT;
        end
      end
      ST_GCNT: begin
        if (!gc_step) begin
          unique case (action_r) inside
            gba_pkg::ACT_ALLOC:                     state_nxt = ST_SCAN;
            gba_pkg::ACT_TAKE, gba_pkg::ACT_RETURN: state_nxt = ST_DIV;
            default:                                state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_stat.hit) begin
          state_nxt = ST_RD;
        end else if (scan_stat.miss) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (g_r == gc_r) begin
          state_nxt = ST_EMIT;
        end else if (32'(rem_r) < 32'(ebpg_r)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      bpg_cfg_r    <= 11'd1024;
      bc_r         <= 13'd4096;
      total_used_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          gba_pkg::REG_BPG:    bpg_cfg_r <= cfg_data[10:0];
          gba_pkg::REG_BCOUNT: bc_r      <= cfg_data;
          default:             bc_r      <= bc_r;
        endcase
      end
      if (state_r == ST_MOD) begin
        total_used_r <= total_mod;
      end
      if (state_r == ST_EMIT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        action_r <= in_tuser;
        target_r <= in_tdata[11:0];
        rem_r    <= in_tdata[11:0];
        ebpg_r   <= ebpg_in;
        gc_r     <= GGW'(1);
        cap_r    <= CW'(ebpg_in);
        g_r      <= '0;
        sb_r     <= '0;
      end
      ST_GCNT: begin
        if (gc_step) begin
          gc_r  <= gc_r + 1'b1;
          cap_r <= cap_r + CW'(ebpg_r);
        end else begin
          res_index_r  <= 12'd0;
          res_status_r <= gba_pkg::STAT_OK;
          res_gfree_r  <= 11'd0;
        end
      end
      ST_SCAN: begin
        op_addr_r    <= hit_addr;
        op_bit_r     <= hit_bit;
        op_g_r       <= hit_g;
        op_set_r     <= 1'b1;
        res_index_r  <= scan_stat.hit ? 12'(hit_index) : 12'd0;
        res_status_r <= scan_stat.hit ? gba_pkg::STAT_OK : gba_pkg::STAT_FULL;
        res_gfree_r  <= 11'd0;
      end
      ST_DIV: begin
        res_index_r <= target_r;
        res_gfree_r <= 11'd0;
        op_addr_r   <= AW'(div_pos >> 5);
        op_bit_r    <= div_pos[4:0];
        op_g_r      <= GW'(g_r);
        op_set_r    <= (action_r == gba_pkg::ACT_TAKE);
        if (g_r == gc_r) begin
          res_status_r <= gba_pkg::STAT_RANGE;
        end else begin
          res_status_r <= gba_pkg::STAT_OK;
          if (32'(rem_r) >= 32'(ebpg_r)) begin
            rem_r <= rem_r - 12'(ebpg_r);
            g_r   <= g_r + 1'b1;
            sb_r  <= sb_r + PXW'(BITS_PER_GROUP);
          end
        end
      end
      ST_MOD: begin
        res_gfree_r <= gfree_mod;
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {4'd0, total_free, res_gfree_r, res_index_r};
          out_tuser_r <= res_status_r;
        end
      end
      default: begin
        op_set_r <= op_set_r;
      end
    endcase
  end

  gba_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  gba_ram #(
    .WIDTH (11),
    .DEPTH (GROUPS)
  ) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata ((state_r == ST_CLR) ? 11'd0 : used_mod),
    .raddr (op_g_r),
    .rdata (used_rdata)
  );

  gba_scan #(
    .GROUPS         (GROUPS),
    .BITS_PER_GROUP (BITS_PER_GROUP)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .ebpg      (ebpg_r),
    .gc        (gc_r),
    .rdata     (bm_rdata),
    .raddr     (scan_raddr),
    .stat      (scan_stat),
    .hit_addr  (hit_addr),
    .hit_bit   (hit_bit),
    .hit_g     (hit_g),
    .hit_index (hit_index)
  );

  a_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_stat.hit && scan_stat.miss))
    else $error("scan reported hit and miss together");

  a_total_upd: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(total_used_r) |-> $past(state_r) == ST_MOD)
    else $error("total used count changed outside the update step");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result presented without an emit step");

  a_no_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !scan_start)
    else $error("scan restarted while running");

endmodule

[rtl/gba_ram.sv]
module gba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/gba_scan.sv]
module gba_scan #(
  parameter int GROUPS         = 4,
  parameter int BITS_PER_GROUP = 1024
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 start,
  input  logic [$clog2(BITS_PER_GROUP+1)-1:0]                  ebpg,
  input  logic [$clog2(GROUPS+1)-1:0]                          gc,
  input  logic [31:0]                                          rdata,
  output logic [((GROUPS*BITS_PER_GROUP+31)/32 > 1 ?
                 $clog2((GROUPS*BITS_PER_GROUP+31)/32) : 1)-1:0] raddr,
  output gba_pkg::scan_stat_t                                  stat,
  output logic [((GROUPS*BITS_PER_GROUP+31)/32 > 1 ?
                 $clog2((GROUPS*BITS_PER_GROUP+31)/32) : 1)-1:0] hit_addr,
  output logic [4:0]                                           hit_bit,
  output logic [(GROUPS > 1 ? $clog2(GROUPS) : 1)-1:0]         hit_g,
  output logic [$clog2(GROUPS*BITS_PER_GROUP+BITS_PER_GROUP+1)-1:0] hit_index
);

  localparam int N     = GROUPS * BITS_PER_GROUP;
  localparam int WORDS = (N + 31) / 32;
  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int GW    = GROUPS > 1 ? $clog2(GROUPS) : 1;
  localparam int GGW   = $clog2(GROUPS + 1);
  localparam int PXW   = $clog2(N + BITS_PER_GROUP + 1);

  // issue stage: walks word addresses group by group
  logic           iss_on_r;
  logic [AW-1:0]  iss_addr_r;
  logic [GW-1:0]  iss_g_r;
  logic [PXW-1:0] iss_sb_r;
  logic [PXW-1:0] iss_gbase_r;
  logic [PXW-1:0] iss_eb;
  logic [AW-1:0]  last_word;
  logic           at_last_word;
  logic           group_last;
  logic [PXW-1:0] p;
  logic [31:0]    mask;

  // check stage: aligned with registered RAM read data
  logic           chk_v_r;
  logic [AW-1:0]  chk_addr_r;
  logic [31:0]    chk_mask_r;
  logic [PXW-1:0] chk_sb_r;
  logic [PXW-1:0] chk_gbase_r;
  logic [GW-1:0]  chk_g_r;
  logic           chk_last_r;
  logic [31:0]    free_bits;
  logic [4:0]     low_bit;

  always_comb begin
    iss_eb       = iss_sb_r + PXW'(ebpg);
    last_word    = AW'((iss_eb - 1'b1) >> 5);
    at_last_word = (iss_addr_r == last_word);
    group_last   = ((GGW'(iss_g_r) + 1'b1) == gc);
    p            = '0;
    for (int j = 0; j < 32; j++) begin
      p       = (PXW'(iss_addr_r) << 5) + PXW'(j);
      mask[j] = (p >= iss_sb_r) && (p < iss_eb);
    end
  end

  always_comb begin
    free_bits = ~rdata & chk_mask_r;
    low_bit   = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (free_bits[j]) begin
        low_bit = 5'(j);
      end
    end
  end

  assign raddr     = iss_addr_r;
  assign stat.hit  = chk_v_r && (|free_bits);
  assign stat.miss = chk_v_r && !(|free_bits) && chk_last_r;
  assign hit_addr  = chk_addr_r;
  assign hit_bit   = low_bit;
  assign hit_g     = chk_g_r;
  assign hit_index = chk_gbase_r + ((PXW'(chk_addr_r) << 5) + PXW'(low_bit) - chk_sb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_on_r <= 1'b0;
      chk_v_r  <= 1'b0;
    end else if (start) begin
      iss_on_r <= 1'b1;
      chk_v_r  <= 1'b0;
    end else if (stat.hit || stat.miss) begin
      iss_on_r <= 1'b0;
      chk_v_r  <= 1'b0;
    end else begin
      chk_v_r <= iss_on_r;
      if (iss_on_r && at_last_word && group_last) begin
        iss_on_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      iss_addr_r  <= '0;
      iss_g_r     <= '0;
      iss_sb_r    <= '0;
      iss_gbase_r <= '0;
    end else if (iss_on_r) begin
      chk_addr_r  <= iss_addr_r;
      chk_mask_r  <= mask;
      chk_sb_r    <= iss_sb_r;
      chk_gbase_r <= iss_gbase_r;
      chk_g_r     <= iss_g_r;
      chk_last_r  <= at_last_word && group_last;
      if (at_last_word) begin
        iss_g_r     <= iss_g_r + 1'b1;
        iss_sb_r    <= iss_sb_r + PXW'(BITS_PER_GROUP);
        iss_gbase_r <= iss_gbase_r + PXW'(ebpg);
        iss_addr_r  <= AW'((iss_sb_r + PXW'(BITS_PER_GROUP)) >> 5);
      end else begin
        iss_addr_r <= iss_addr_r + 1'b1;
      end
    end
  end

endmodule
